### hw/rtl/sbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Holds the controller state type and the controller/datapath command
// and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

  // Fixed field widths of the ports.
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int POS_W  = 4;

  // Default table depth and reset value of the last index register.
  localparam int               TABLE_DEPTH_DEFAULT = 16;
  localparam logic [IDX_W-1:0] LAST_INDEX_RESET    = 4'd9;

  // Operation codes of an input word.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_PROBE,
    S_CMP
  } sbs_state_t;

  // Table read address select.
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID
  } sbs_rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        wr_entry;    // write the input word into the table
    logic        load;        // capture key and last index
    sbs_rd_sel_t rd_sel;      // table read address
    logic        chk_last;    // compare key against the last entry
    logic        init_range;  // set the search range to [0, last]
    logic        step;        // narrow the range after a probe
    logic        finish_miss; // deliver a not-found result
    logic        finish_hit;  // deliver a found result at the midpoint
  } sbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic above_last;   // key was above the last entry
    logic key_lt;       // key below the entry just read
    logic key_eq;       // key equal to the entry just read
    logic range_empty;  // low bound passed the high bound
  } sbs_status_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_table_binary_search.sv
// Sorted table binary search: a write word gives no result. A search first checks
// the last and the first entries, then reads and compares the midpoint once per probe
// (at most log2(depth)+1 probes) and sees an empty range in S_PROBE on a miss;
// the strobe comes the cycle after the deciding check, and the next word can be
// taken in that cycle. busy is high during a search and in reset; synchronous
// active-low reset clears controller, bounds, strobe.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [sbs_pkg::IDX_W-1:0]         cfg_wr_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_opcode,
  input  wire logic [sbs_pkg::IDX_W-1:0]         in_entry_index,
  input  wire logic signed [sbs_pkg::DATA_W-1:0] in_item_value,
  output logic                                   out_valid,
  output logic                                   out_found,
  output logic [sbs_pkg::POS_W-1:0]              out_position
);

  import sbs_pkg::*;

  sbs_cmd_t    cmd;
  sbs_status_t status;

  // Controller.
  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Datapath.
  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_entry_index (in_entry_index),
    .in_item_value  (in_item_value),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule

`default_nettype wire

### hw/rtl/sbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/sbs_ctrl.sv
// Controller state machine of the binary search block.
// Depends on sbs_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_opcode,
  input  wire sbs_pkg::sbs_status_t status,
  output sbs_pkg::sbs_cmd_t        cmd,
  output logic                     busy
);

  import sbs_pkg::*;

  sbs_state_t state_r;
  sbs_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && in_opcode == OP_SEARCH) begin
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST:  state_nxt = S_RD_FIRST;
      S_RD_FIRST: state_nxt = S_CHK_FIRST;
      S_CHK_FIRST: begin
        if (status.above_last || status.key_lt) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.range_empty) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (status.key_eq) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs. No word is taken while reset is held.
  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_FIRST;
    busy            = (state_r != S_IDLE) || !rst_n;
    case (state_r)
      S_IDLE: begin
        cmd.wr_entry = rst_n && start && in_opcode == OP_WRITE;
        cmd.load     = rst_n && start && in_opcode == OP_SEARCH;
      end
      S_RD_LAST: begin
        cmd.rd_sel = RD_LAST;
      end
      S_RD_FIRST: begin
        cmd.rd_sel   = RD_FIRST;
        cmd.chk_last = 1'b1;
      end
      S_CHK_FIRST: begin
        if (status.above_last || status.key_lt) begin
          cmd.finish_miss = 1'b1;
        end else begin
          cmd.init_range = 1'b1;
        end
      end
      S_PROBE: begin
        cmd.rd_sel = RD_MID;
        if (status.range_empty) begin
          cmd.finish_miss = 1'b1;
        end
      end
      S_CMP: begin
        cmd.rd_sel = RD_MID;
        if (status.key_eq) begin
          cmd.finish_hit = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        cmd.rd_sel = RD_FIRST;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/sbs_datapath.sv
// Datapath of the binary search block: table RAM, key, range bounds,
// comparators and the result register.
// Depends on sbs_pkg and sbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module sbs_datapath #(
  parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sbs_pkg::IDX_W-1:0]    cfg_wr_data,
  input  wire logic [sbs_pkg::IDX_W-1:0]    in_entry_index,
  input  wire logic signed [sbs_pkg::DATA_W-1:0] in_item_value,
  input  wire sbs_pkg::sbs_cmd_t            cmd,
  output sbs_pkg::sbs_status_t              status,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [sbs_pkg::POS_W-1:0]         out_position
);

  import sbs_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int RW   = AW + 2;        // signed range bound width
  localparam int EXTW = AW + IDX_W;    // common width for index compares

  // Last index register, written by the configuration port.
  logic [IDX_W-1:0] last_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_index_r <= LAST_INDEX_RESET;
    end else if (cfg_wr_en) begin
      last_index_r <= cfg_wr_data;
    end
  end

  // Last index saturated to the table.
  logic [EXTW-1:0] last_ext;
  logic [AW-1:0]   last_sat;

  always_comb begin
    last_ext = EXTW'(last_index_r);
    if (last_ext > EXTW'(TABLE_DEPTH - 1)) begin
      last_sat = AW'(TABLE_DEPTH - 1);
    end else begin
      last_sat = last_ext[AW-1:0];
    end
  end

  // Key and last index captured at the start of a search.
  logic signed [DATA_W-1:0] key_r;
  logic [AW-1:0]            last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_item_value;
      last_r <= last_sat;
    end
  end

  // Range bounds and midpoint.
  logic signed [RW-1:0] lo_r, lo_nxt;
  logic signed [RW-1:0] hi_r, hi_nxt;
  logic [RW-1:0]        bound_sum;
  logic [AW-1:0]        mid;

  assign bound_sum = lo_r + hi_r;
  assign mid       = bound_sum[AW:1];

  // Table write address, dropped when beyond the table.
  logic [EXTW-1:0] wr_idx_ext;
  logic            wr_ok;

  assign wr_idx_ext = EXTW'(in_entry_index);
  assign wr_ok      = wr_idx_ext < EXTW'(TABLE_DEPTH);

  // Table read address select.
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST:  rd_addr = last_r;
      RD_MID:   rd_addr = mid;
      default:  rd_addr = '0;
    endcase
  end

  sbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (cmd.wr_entry && wr_ok),
    .wr_addr   (wr_idx_ext[AW-1:0]),
    .wr_data   (in_item_value),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  // Comparators against the entry just read.
  logic signed [DATA_W-1:0] entry;
  logic                     key_lt;
  logic                     key_gt;

  assign entry  = $signed(rd_data_r);
  assign key_lt = key_r < entry;
  assign key_gt = key_r > entry;

  // Rejection flag for a key above the last entry.
  logic above_last_r;

  always_ff @(posedge clk) begin
    if (cmd.chk_last) begin
      above_last_r <= key_gt;
    end
  end

  // Range bound update.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.init_range) begin
      lo_nxt = '0;
      hi_nxt = RW'(last_r);
    end else if (cmd.step) begin
      if (key_lt) begin
        hi_nxt = RW'(mid) - RW'(1);
      end else begin
        lo_nxt = RW'(mid) + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_comb begin
    status             = '0;
    status.above_last  = above_last_r;
    status.key_lt      = key_lt;
    status.key_eq      = !key_lt && !key_gt;
    status.range_empty = lo_r > hi_r;
  end

  // Result register: one strobed word per search.
  logic [EXTW-1:0]  mid_ext;
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;

  assign mid_ext = EXTW'(mid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish_hit || cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      out_found_r    <= 1'b1;
      out_position_r <= mid_ext[POS_W-1:0];
    end else if (cmd.finish_miss) begin
      out_found_r    <= 1'b0;
      out_position_r <= '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

`default_nettype wire
